// ===== rtl/core/mstk_pkg.sv =====
// Package with the shared types and constants of the min-tracking stack.
`timescale 1ns / 1ps

package mstk_pkg;

  // Command carried in the input tuser field.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Widths of the data fields.
  localparam int unsigned DataW = 32;

  // One stack entry: the pushed value and the minimum at that depth.
  typedef struct packed {
    logic [DataW-1:0] min_value;
    logic [DataW-1:0] top_value;
  } entry_t;

  // Output tuser fields, lowest bit first: is_empty, status.
  typedef struct packed {
    status_e status;
    logic    is_empty;
  } res_flags_t;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

endpackage

// ===== rtl/core/mstk_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module mstk_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/min_tracking_stack.sv =====
// Top level of the min-tracking stack: controller, top-of-stack cache and result register.
`timescale 1ns / 1ps

// A LIFO stack of signed 32-bit values that also reports the running minimum.
// Each input transaction is a push (tuser = 0) or a pop (tuser = 1) and
// yields exactly one result transaction with the top entry, the minimum, an
// empty flag and a status. The top entry and its minimum are held in a
// register; all deeper entries live in one RAM with a registered read. A push,
// a rejected command and a pop that empties the stack are handled in S_IDLE;
// a pop that leaves entries behind also passes through S_READ, because the new
// top must be read back from the RAM before the next command is taken. A new
// command is accepted while a finished result is being taken downstream. The
// RAM needs no clearing after reset: only entries below the count are ever read.
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input tdata: value[31:0]
  input  logic [31:0] s_axis_tdata,
  // Input tuser: command[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Output tdata: top_value[31:0], min_value[63:32]
  output logic [63:0] m_axis_tdata,
  // Output tuser: is_empty[0], status[2:1]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  import mstk_pkg::*;

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  entry_t          cache_q, cache_d;
  logic            out_valid_q, out_valid_d;
  entry_t          out_data_q, out_data_d;
  res_flags_t      out_flags_q, out_flags_d;

  logic             accept;
  logic             full;
  logic [CntW-1:0]  cnt_m1, cnt_m2;
  logic [31:0]      new_min;
  logic             ram_we, ram_re;
  entry_t           ram_rdata;
  logic [AddrW-1:0] ram_waddr, ram_raddr;

  // Deeper entries of the stack.
  mstk_ram #(
    .Width ($bits(entry_t)),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cache_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(STACK_DEPTH));
  assign cnt_m1        = count_q - CntW'(1);
  assign cnt_m2        = count_q - CntW'(2);
  assign ram_waddr     = cnt_m1[AddrW-1:0];
  assign ram_raddr     = cnt_m2[AddrW-1:0];

  // The new minimum entry: the pushed value unless the current minimum is smaller.
  assign new_min = ((count_q == '0) || ($signed(s_axis_tdata) <= $signed(cache_q.min_value)))
                   ? s_axis_tdata : cache_q.min_value;

  // Command handling and result formation.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cache_d     = cache_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_flags_d = out_flags_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == CMD_POP) begin
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
              out_flags_d = '{status: ST_EMPTY, is_empty: 1'b1};
            end else if (count_q == CntW'(1)) begin
              count_d     = cnt_m1;
              out_valid_d = 1'b1;
              out_data_d  = '0;
              out_flags_d = '{status: ST_OK, is_empty: 1'b1};
            end else begin
              // Fetch the new top; the result follows once it arrives.
              count_d = cnt_m1;
              ram_re  = 1'b1;
              state_d = S_READ;
            end
          end else begin
            if (full) begin
              out_valid_d = 1'b1;
              out_data_d  = cache_q;
              out_flags_d = '{status: ST_FULL, is_empty: 1'b0};
            end else begin
              // Spill the old top to the RAM and cache the new one.
              ram_we      = (count_q != '0);
              cache_d     = '{min_value: new_min, top_value: s_axis_tdata};
              count_d     = count_q + CntW'(1);
              out_valid_d = 1'b1;
              out_data_d  = '{min_value: new_min, top_value: s_axis_tdata};
              out_flags_d = '{status: ST_OK, is_empty: 1'b0};
            end
          end
        end
      end
      S_READ: begin
        cache_d     = ram_rdata;
        out_valid_d = 1'b1;
        out_data_d  = ram_rdata;
        out_flags_d = '{status: ST_OK, is_empty: 1'b0};
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Top-of-stack cache and result payload.
  always_ff @(posedge clk_i) begin
    cache_q     <= cache_d;
    out_data_q  <= out_data_d;
    out_flags_q <= out_flags_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flags_q;

endmodule

// ===== rtl/core/mstk_checker.sv =====
// Port-level checker for the min-tracking stack, bound to the top level.
`timescale 1ns / 1ps

module mstk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  import mstk_pkg::*;

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An empty stack reports zero for both the top and the minimum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
    else $error("empty result carries data");

  // A rejected pop only happens on an empty stack, a rejected push never does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[2:1] == ST_EMPTY && m_axis_tuser[0]) ||
      (m_axis_tuser[2:1] == ST_FULL && !m_axis_tuser[0]) ||
      (m_axis_tuser[2:1] == ST_OK))
    else $error("status and empty flag disagree");

  // The minimum never exceeds the top entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      $signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[31:0]))
    else $error("minimum above top entry");

  // An accepted push of a value yields that value on top unless the stack was full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_PUSH |=>
      m_axis_tvalid &&
      (m_axis_tdata[31:0] == $past(s_axis_tdata) || m_axis_tuser[2:1] == ST_FULL))
    else $error("pushed value not on top");

endmodule

bind min_tracking_stack mstk_checker u_mstk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
